### rtl/core/mdd_pkg.sv
`default_nettype none
package mdd_pkg;

   parameter int COORD_W   = 32;
   parameter int RADIUS_W  = 31;
   parameter int DIFF_W    = 33;   // p - c, exact
   parameter int MAG_W     = 32;   // |p - c| never reaches 2^32
   parameter int SQ_W      = 64;
   parameter int D2_W      = 65;
   parameter int RSQ_W     = 62;
   parameter int FAC_SHIFT = 60;   // 2 * factor fraction bits
   parameter int NUM_W     = RSQ_W + FAC_SHIFT;  // dividend bits, one cell each
   parameter int DIV_STEPS = NUM_W;
   parameter int SQRT_IN_W = 124;
   parameter int SQRT_STEPS = SQRT_IN_W / 2;
   parameter int ROOT_W    = SQRT_STEPS;
   parameter int SREM_W    = ROOT_W + 1;
   parameter int FACTOR_FRAC = 30;
   parameter int OFF_W     = 34;   // offset magnitude, clamped to 2^33
   parameter int CSR_IDX_W = 2;

   parameter logic [CSR_IDX_W-1:0] CSR_CENTER_X = 2'd0;
   parameter logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 2'd1;
   parameter logic [CSR_IDX_W-1:0] CSR_RADIUS   = 2'd2;

   parameter logic [SQRT_IN_W-1:0] ONE_Q = SQRT_IN_W'(1) << FAC_SHIFT;

   typedef struct packed {
      logic                     valid;
      logic                     last;
      logic                     center;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
   } side_type;

   typedef struct packed {
      logic [D2_W-1:0]  rem;
      logic [NUM_W-1:0] nq;   // dividend bits shift out, quotient bits shift in
      logic [D2_W-1:0]  d2;
   } div_type;

   typedef struct packed {
      logic [SREM_W-1:0]    rem;
      logic [SQRT_IN_W-1:0] val;
      logic [ROOT_W-1:0]    root;
   } sqrt_type;

endpackage
`default_nettype wire

### rtl/core/mdd_div_cell.sv
`default_nettype none
module mdd_div_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  mdd_pkg::side_type      side_in,
   input  mdd_pkg::div_type       div_in,
   output mdd_pkg::side_type      side_out,
   output mdd_pkg::div_type       div_out
);

   mdd_pkg::side_type side_ff;
   mdd_pkg::div_type  div_ff, div_in_c;
   logic [mdd_pkg::D2_W:0] trial;
   logic [mdd_pkg::D2_W:0] diff;
   logic                   take;

   // one restoring step
   always_comb begin
      trial = {div_in.rem, div_in.nq[mdd_pkg::NUM_W-1]};
      diff  = trial - {1'b0, div_in.d2};
      take  = trial >= {1'b0, div_in.d2};
      div_in_c.rem = take ? diff[mdd_pkg::D2_W-1:0] : trial[mdd_pkg::D2_W-1:0];
      div_in_c.nq  = {div_in.nq[mdd_pkg::NUM_W-2:0], take};
      div_in_c.d2  = div_in.d2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else if (en) begin
         side_ff <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff <= div_in_c;
      end
   end

   assign side_out = side_ff;
   assign div_out  = div_ff;

endmodule
`default_nettype wire

### rtl/core/mdd_sqrt_cell.sv
`default_nettype none
module mdd_sqrt_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  mdd_pkg::side_type      side_in,
   input  mdd_pkg::sqrt_type      sq_in,
   output mdd_pkg::side_type      side_out,
   output mdd_pkg::sqrt_type      sq_out
);

   mdd_pkg::side_type side_ff;
   mdd_pkg::sqrt_type sq_ff, sq_in_c;
   logic [mdd_pkg::SREM_W+1:0] part;
   logic [mdd_pkg::SREM_W+1:0] trial;
   logic [mdd_pkg::SREM_W+1:0] diff;
   logic                       take;

   // one root bit per cell
   always_comb begin
      part  = {sq_in.rem, sq_in.val[mdd_pkg::SQRT_IN_W-1 -: 2]};
      trial = {1'b0, sq_in.root, 2'b01};
      diff  = part - trial;
      take  = part >= trial;
      sq_in_c.rem  = take ? diff[mdd_pkg::SREM_W-1:0] : part[mdd_pkg::SREM_W-1:0];
      sq_in_c.val  = {sq_in.val[mdd_pkg::SQRT_IN_W-3:0], 2'b00};
      sq_in_c.root = {sq_in.root[mdd_pkg::ROOT_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else if (en) begin
         side_ff <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_in_c;
      end
   end

   assign side_out = side_ff;
   assign sq_out   = sq_ff;

endmodule
`default_nettype wire

### rtl/core/mdd_place.sv
`default_nettype none
module mdd_place (
   input  wire logic                                 clock,
   input  wire logic                                 en,
   input  wire logic signed [mdd_pkg::DIFF_W-1:0]    d,
   input  wire logic        [mdd_pkg::ROOT_W-1:0]    factor,
   input  wire logic signed [mdd_pkg::COORD_W-1:0]   center,
   output logic signed      [mdd_pkg::COORD_W-1:0]   coord,
   output logic                                      clip
);

   localparam int HI_W   = mdd_pkg::ROOT_W - 32;
   localparam int PROD_W = mdd_pkg::MAG_W + mdd_pkg::ROOT_W;
   localparam int SUM_W  = mdd_pkg::OFF_W + 1;

   logic [mdd_pkg::DIFF_W-1:0] mag_full;
   logic [mdd_pkg::MAG_W-1:0]  mag;
   logic [63:0]                p0_ff, p0_in;
   logic [mdd_pkg::MAG_W+HI_W-1:0] p1_ff, p1_in;
   logic                       neg1_ff, neg2_ff;
   logic [PROD_W-1:0]          prod;
   logic [PROD_W-mdd_pkg::FACTOR_FRAC-1:0] shifted;
   logic [mdd_pkg::OFF_W-1:0]  m_ff, m_in;
   logic signed [SUM_W-1:0]    off;
   logic signed [SUM_W-1:0]    sum;
   logic signed [mdd_pkg::COORD_W-1:0] coord_ff, coord_in;
   logic                       clip_ff, clip_in;

   localparam logic [mdd_pkg::OFF_W-1:0] OFF_MAX = mdd_pkg::OFF_W'(1) << (mdd_pkg::OFF_W - 1);
   localparam logic signed [SUM_W-1:0] S_MAX = SUM_W'(32'sh7fffffff);
   localparam logic signed [SUM_W-1:0] S_MIN = -SUM_W'(33'sh080000000);

   always_comb begin
      mag_full = d[mdd_pkg::DIFF_W-1] ? -d : d;
      mag      = mag_full[mdd_pkg::MAG_W-1:0];
      p0_in    = 64'(mag) * 64'(factor[31:0]);
      p1_in    = (mdd_pkg::MAG_W+HI_W)'(mag) * (mdd_pkg::MAG_W+HI_W)'(factor[mdd_pkg::ROOT_W-1:32]);
   end

   always_comb begin
      prod    = PROD_W'(p0_ff) + (PROD_W'(p1_ff) << 32);
      shifted = prod[PROD_W-1:mdd_pkg::FACTOR_FRAC];
      m_in    = (shifted > (PROD_W-mdd_pkg::FACTOR_FRAC)'(OFF_MAX)) ?
                OFF_MAX : shifted[mdd_pkg::OFF_W-1:0];
   end

   always_comb begin
      off = neg2_ff ? -$signed({1'b0, m_ff}) : $signed({1'b0, m_ff});
      sum = SUM_W'(center) + off;
      if (sum > S_MAX) begin
         coord_in = mdd_pkg::COORD_W'(S_MAX);
         clip_in  = 1'b1;
      end else if (sum < S_MIN) begin
         coord_in = mdd_pkg::COORD_W'(S_MIN);
         clip_in  = 1'b1;
      end else begin
         coord_in = sum[mdd_pkg::COORD_W-1:0];
         clip_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff    <= p0_in;
         p1_ff    <= p1_in;
         neg1_ff  <= d[mdd_pkg::DIFF_W-1];
         m_ff     <= m_in;
         neg2_ff  <= neg1_ff;
         coord_ff <= coord_in;
         clip_ff  <= clip_in;
      end
   end

   assign coord = coord_ff;
   assign clip  = clip_ff;

endmodule
`default_nettype wire

### rtl/core/marbling_drop_displace_top.sv
// marbling drop displacement: moves each polygon vertex away from a paint
// drop center by p' = c + (p - c) * sqrt(1 + r^2 / |p - c|^2)
//
// request channel: req_valid / req_ready with point_x, point_y (Q16.16)
// and last_vertex; response channel: rsp_valid / rsp_ready with moved_x,
// moved_y, clipped, at_center and last_out, one response per request
// csr port: write center_x, center_y, radius by index while idle
//
// throughput: one request per cycle unless stalled, one pipeline path
// path: a request passes the setup stages, the chain of 122 divider
// cells (one quotient bit each), a unit-term stage, 62 square root
// cells (one root bit each) and multiply / place stages to rsp_valid
//
// stall: when a response waits and rsp_ready is low the whole pipeline
// holds and req_ready drops; bubbles keep flowing otherwise
// reset: clears all stage valid bits and the drop registers to zero
`default_nettype none
module marbling_drop_displace_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [mdd_pkg::COORD_W-1:0]    req_point_x,
   input  wire logic signed [mdd_pkg::COORD_W-1:0]    req_point_y,
   input  wire logic                                  req_last_vertex,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed      [mdd_pkg::COORD_W-1:0]    rsp_moved_x,
   output logic signed      [mdd_pkg::COORD_W-1:0]    rsp_moved_y,
   output logic                                       rsp_clipped,
   output logic                                       rsp_at_center,
   output logic                                       rsp_last_out,
   input  wire logic                                  csr_wr_en,
   input  wire logic        [mdd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [mdd_pkg::COORD_W-1:0]    csr_data
);

   // drop registers
   logic signed [mdd_pkg::COORD_W-1:0] cx_ff, cy_ff;
   logic [mdd_pkg::RADIUS_W-1:0]       r_ff;

   logic en;

   // front stages
   mdd_pkg::side_type side_a_ff, side_a_in, side_b_ff, side_c_ff;
   logic [mdd_pkg::DIFF_W-1:0] ax_full, ay_full;
   logic [mdd_pkg::SQ_W-1:0]   sqx_ff, sqy_ff;
   logic [mdd_pkg::RSQ_W-1:0]  r_sq;
   mdd_pkg::div_type           div_c_ff, div_c_in;

   // cell chains
   mdd_pkg::side_type side_div [0:mdd_pkg::DIV_STEPS];
   mdd_pkg::div_type  div_st   [0:mdd_pkg::DIV_STEPS];
   mdd_pkg::side_type side_v_ff;
   mdd_pkg::sqrt_type sq_v_ff, sq_v_in;
   mdd_pkg::side_type side_sq  [0:mdd_pkg::SQRT_STEPS];
   mdd_pkg::sqrt_type sq_st    [0:mdd_pkg::SQRT_STEPS];

   // place stages, side data rides alongside
   mdd_pkg::side_type side_p_ff [0:2];
   logic clip_x, clip_y;

   // config writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
         r_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            mdd_pkg::CSR_CENTER_X: cx_ff <= csr_data;
            mdd_pkg::CSR_CENTER_Y: cy_ff <= csr_data;
            mdd_pkg::CSR_RADIUS:   r_ff  <= csr_data[mdd_pkg::RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipe moves unless the output holds an untaken response
   assign en        = !side_p_ff[2].valid || rsp_ready;
   assign req_ready = en;

   // stage a: differences from the center
   always_comb begin
      side_a_in.valid  = req_valid;
      side_a_in.last   = req_last_vertex;
      side_a_in.dx     = mdd_pkg::DIFF_W'(req_point_x) - mdd_pkg::DIFF_W'(cx_ff);
      side_a_in.dy     = mdd_pkg::DIFF_W'(req_point_y) - mdd_pkg::DIFF_W'(cy_ff);
      side_a_in.center = (side_a_in.dx == '0) && (side_a_in.dy == '0);
   end

   // stage b: squares, stage c: d^2 sum and r^2 dividend
   always_comb begin
      ax_full      = side_a_ff.dx[mdd_pkg::DIFF_W-1] ? -side_a_ff.dx : side_a_ff.dx;
      ay_full      = side_a_ff.dy[mdd_pkg::DIFF_W-1] ? -side_a_ff.dy : side_a_ff.dy;
      r_sq         = mdd_pkg::RSQ_W'(r_ff) * mdd_pkg::RSQ_W'(r_ff);
      div_c_in.rem = '0;
      div_c_in.nq  = {r_sq, {mdd_pkg::FAC_SHIFT{1'b0}}};
      div_c_in.d2  = mdd_pkg::D2_W'(sqx_ff) + mdd_pkg::D2_W'(sqy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_a_ff <= '0;
         side_b_ff <= '0;
         side_c_ff <= '0;
      end else if (en) begin
         side_a_ff <= side_a_in;
         side_b_ff <= side_a_ff;
         side_c_ff <= side_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff   <= 64'(ax_full[mdd_pkg::MAG_W-1:0]) * 64'(ax_full[mdd_pkg::MAG_W-1:0]);
         sqy_ff   <= 64'(ay_full[mdd_pkg::MAG_W-1:0]) * 64'(ay_full[mdd_pkg::MAG_W-1:0]);
         div_c_ff <= div_c_in;
      end
   end

   // divider chain: floor(r^2 * 2^60 / d^2)
   assign side_div[0] = side_c_ff;
   assign div_st[0]   = div_c_ff;

   for (genvar i = 0; i < mdd_pkg::DIV_STEPS; i++) begin : g_div
      mdd_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .side_in  (side_div[i]),
         .div_in   (div_st[i]),
         .side_out (side_div[i+1]),
         .div_out  (div_st[i+1])
      );
   end

   // add the unit term: (d^2 + r^2) * 2^60 / d^2
   always_comb begin
      sq_v_in.rem  = '0;
      sq_v_in.val  = mdd_pkg::SQRT_IN_W'(div_st[mdd_pkg::DIV_STEPS].nq) + mdd_pkg::ONE_Q;
      sq_v_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_v_ff <= '0;
      end else if (en) begin
         side_v_ff <= side_div[mdd_pkg::DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_v_ff <= sq_v_in;
      end
   end

   // square root chain gives the UQ.30 factor
   assign side_sq[0] = side_v_ff;
   assign sq_st[0]   = sq_v_ff;

   for (genvar j = 0; j < mdd_pkg::SQRT_STEPS; j++) begin : g_sqrt
      mdd_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .side_in  (side_sq[j]),
         .sq_in    (sq_st[j]),
         .side_out (side_sq[j+1]),
         .sq_out   (sq_st[j+1])
      );
   end

   // scale the offset and place it around the center, per axis
   mdd_place u_place_x (
      .clock  (clock),
      .en     (en),
      .d      (side_sq[mdd_pkg::SQRT_STEPS].dx),
      .factor (sq_st[mdd_pkg::SQRT_STEPS].root),
      .center (cx_ff),
      .coord  (rsp_moved_x),
      .clip   (clip_x)
   );

   mdd_place u_place_y (
      .clock  (clock),
      .en     (en),
      .d      (side_sq[mdd_pkg::SQRT_STEPS].dy),
      .factor (sq_st[mdd_pkg::SQRT_STEPS].root),
      .center (cy_ff),
      .coord  (rsp_moved_y),
      .clip   (clip_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         side_p_ff[0] <= '0;
         side_p_ff[1] <= '0;
         side_p_ff[2] <= '0;
      end else if (en) begin
         side_p_ff[0] <= side_sq[mdd_pkg::SQRT_STEPS];
         side_p_ff[1] <= side_p_ff[0];
         side_p_ff[2] <= side_p_ff[1];
      end
   end

   // at the center the offset is zero, so the result is the vertex itself
   assign rsp_valid     = side_p_ff[2].valid;
   assign rsp_clipped   = clip_x | clip_y;
   assign rsp_at_center = side_p_ff[2].center;
   assign rsp_last_out  = side_p_ff[2].last;

endmodule
`default_nettype wire

### rtl/core/mdd_checker.sv
`default_nettype none
module mdd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_moved_x,
   input wire logic [31:0] rsp_moved_y,
   input wire logic        rsp_clipped,
   input wire logic        rsp_at_center,
   input wire logic        rsp_last_out
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_moved_x)
         && $stable(rsp_moved_y) && $stable(rsp_last_out))
      else $error("stalled response changed");

   // a center hit never saturates
   a_center_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_at_center |-> !rsp_clipped)
      else $error("center vertex flagged clipped");

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response out of reset");

   // an empty output never blocks requests
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output");

endmodule

bind marbling_drop_displace_top mdd_checker u_mdd_checker (.*);
`default_nettype wire
